### rtl/clr_pkg.sv
// Shared types, constants and name tables of the command line recognizer.
package clr_pkg;

  localparam int NAME_MAX = 20;
  localparam int ARG_MAX  = 40;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CASE_OFFSET = 8'd32;

  typedef enum logic [3:0] {
    PH_NAME     = 4'd0,
    PH_A1_START = 4'd1,
    PH_A1_BODY  = 4'd2,
    PH_A2_START = 4'd3,
    PH_A2_BODY  = 4'd4,
    PH_CR       = 4'd5,
    PH_LF       = 4'd6,
    PH_SKIP     = 4'd7
  } clr_phase_e;

  typedef enum logic [1:0] {
    CMD_LOGIN   = 2'd0,
    CMD_METRICS = 2'd1,
    CMD_FINISH  = 2'd2,
    CMD_NONE    = 2'd3
  } clr_cmd_e;

  typedef enum logic [1:0] {
    RES_NONE = 2'd0,
    RES_CHAR = 2'd1,
    RES_FAIL = 2'd2,
    RES_OK   = 2'd3
  } clr_res_e;

  // Command names in upper case, padded with zeros.
  localparam logic [7:0] CMD_TEXT [3][8] = '{
    '{"L", "O", "G", "I", "N", 8'h00, 8'h00, 8'h00},
    '{"M", "E", "T", "R", "I", "C", "S", 8'h00},
    '{"F", "I", "N", "I", "S", "H", 8'h00, 8'h00}
  };
  localparam logic [4:0] CMD_LEN [3] = '{5'd5, 5'd7, 5'd6};

  typedef struct packed {
    clr_phase_e  phase;
    logic [4:0]  name_count;
    logic [2:0]  name_alive;
    logic [5:0]  arg_count;
    logic        first_present;
    logic        second_present;
    logic [5:0]  first_length;
    logic [5:0]  second_length;
    clr_cmd_e    chosen_command;
  } clr_state_t;

  localparam clr_state_t STATE_RESET = '{
    phase:          PH_NAME,
    name_count:     5'd0,
    name_alive:     3'b111,
    arg_count:      6'd0,
    first_present:  1'b0,
    second_present: 1'b0,
    first_length:   6'd0,
    second_length:  6'd0,
    chosen_command: CMD_NONE
  };

  typedef struct packed {
    logic        kind;
    logic [1:0]  arg_number;
    logic [7:0]  arg_char;
    logic        line_ok;
    clr_cmd_e    command_code;
    logic        first_arg_present;
    logic        second_arg_present;
    logic [5:0]  first_arg_length;
    logic [5:0]  second_arg_length;
  } clr_result_t;

  // One parser step: the line state after the byte and the result it causes.
  typedef struct packed {
    clr_state_t  next_state;
    logic        emit;
    clr_result_t result;
  } clr_step_t;

endpackage

### rtl/clr_if.sv
// Valid/ready channel interfaces for command bytes and recognizer results.
interface clr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       chunk_end;

  modport source (output valid, output data_byte, output chunk_end, input ready);
  modport sink   (input valid, input data_byte, input chunk_end, output ready);
endinterface

interface clr_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [1:0] arg_number;
  logic [7:0] arg_char;
  logic       line_ok;
  logic [1:0] command_code;
  logic       first_arg_present;
  logic       second_arg_present;
  logic [5:0] first_arg_length;
  logic [5:0] second_arg_length;

  modport source (
    output valid, output kind, output arg_number, output arg_char, output line_ok,
    output command_code, output first_arg_present, output second_arg_present,
    output first_arg_length, output second_arg_length, input ready
  );
  modport sink (
    input valid, input kind, input arg_number, input arg_char, input line_ok,
    input command_code, input first_arg_present, input second_arg_present,
    input first_arg_length, input second_arg_length, output ready
  );
endinterface

### rtl/clr_parser.sv
// Combinational parse step: line state and one byte in, next state and result out.
module clr_parser (
  input  clr_pkg::clr_state_t state_i,
  input  logic [7:0]          data_byte_i,
  input  logic                chunk_end_i,
  output clr_pkg::clr_step_t  step_o
);

  clr_pkg::clr_state_t nxt;
  clr_pkg::clr_res_e   res;
  clr_pkg::clr_cmd_e   sel;
  logic [1:0]          argn;
  logic [7:0]          upper;
  logic                name_end;
  logic                arg_end;

  always_comb begin
    nxt   = state_i;
    res   = clr_pkg::RES_NONE;
    argn  = 2'd0;
    upper = (data_byte_i inside {["a":"z"]}) ? data_byte_i - clr_pkg::CASE_OFFSET
                                             : data_byte_i;
    name_end = (state_i.name_count >= 5'(clr_pkg::NAME_MAX)) ||
               (data_byte_i == clr_pkg::CH_SPACE) || (data_byte_i == clr_pkg::CH_CR);
    arg_end  = (state_i.arg_count >= 6'(clr_pkg::ARG_MAX)) ||
               (data_byte_i == clr_pkg::CH_SPACE) || (data_byte_i == clr_pkg::CH_CR);

    // Lowest surviving candidate of matching length wins.
    sel = clr_pkg::CMD_NONE;
    for (int k = 2; k >= 0; k--) begin
      if (state_i.name_alive[k] && (state_i.name_count == clr_pkg::CMD_LEN[k])) begin
        sel = clr_pkg::clr_cmd_e'(k[1:0]);
      end
    end

    case (state_i.phase)
      clr_pkg::PH_NAME: begin
        if (name_end) begin
          if ((state_i.name_count == 5'd0) || (sel == clr_pkg::CMD_NONE)) begin
            res = clr_pkg::RES_FAIL;
          end else begin
            nxt.chosen_command = sel;
            // The ending byte is taken by the following stage right away.
            if (data_byte_i == clr_pkg::CH_CR) begin
              nxt.phase = clr_pkg::PH_LF;
            end else if ((sel == clr_pkg::CMD_LOGIN) &&
                         (data_byte_i == clr_pkg::CH_SPACE)) begin
              nxt.arg_count = 6'd0;
              nxt.phase     = clr_pkg::PH_A1_BODY;
            end else begin
              res = clr_pkg::RES_FAIL;
            end
          end
        end else if (!(data_byte_i inside {["A":"Z"], ["a":"z"]}) &&
                     (data_byte_i != clr_pkg::CH_UNDER)) begin
          res = clr_pkg::RES_FAIL;
        end else begin
          for (int k = 0; k < 3; k++) begin
            if ((state_i.name_count >= clr_pkg::CMD_LEN[k]) ||
                (clr_pkg::CMD_TEXT[k][state_i.name_count[2:0]] != upper)) begin
              nxt.name_alive[k] = 1'b0;
            end
          end
          nxt.name_count = state_i.name_count + 5'd1;
        end
      end
      clr_pkg::PH_A1_START, clr_pkg::PH_A2_START: begin
        if (data_byte_i == clr_pkg::CH_CR) begin
          nxt.phase = clr_pkg::PH_LF;
        end else if (data_byte_i == clr_pkg::CH_SPACE) begin
          nxt.arg_count = 6'd0;
          nxt.phase = (state_i.phase == clr_pkg::PH_A1_START) ? clr_pkg::PH_A1_BODY
                                                               : clr_pkg::PH_A2_BODY;
        end else begin
          res = clr_pkg::RES_FAIL;
        end
      end
      clr_pkg::PH_A1_BODY: begin
        if (arg_end) begin
          if (state_i.arg_count == 6'd0) begin
            res = clr_pkg::RES_FAIL;
          end else begin
            nxt.first_present = 1'b1;
            nxt.first_length  = state_i.arg_count;
            if (data_byte_i == clr_pkg::CH_CR) begin
              nxt.phase = clr_pkg::PH_LF;
            end else if (data_byte_i == clr_pkg::CH_SPACE) begin
              nxt.arg_count = 6'd0;
              nxt.phase     = clr_pkg::PH_A2_BODY;
            end else begin
              res = clr_pkg::RES_FAIL;
            end
          end
        end else if (!(data_byte_i inside {[clr_pkg::CH_BANG:clr_pkg::CH_TILDE]})) begin
          res = clr_pkg::RES_FAIL;
        end else begin
          argn          = 2'd1;
          nxt.arg_count = state_i.arg_count + 6'd1;
          res           = clr_pkg::RES_CHAR;
        end
      end
      clr_pkg::PH_A2_BODY: begin
        if (arg_end) begin
          if (state_i.arg_count == 6'd0) begin
            res = clr_pkg::RES_FAIL;
          end else begin
            nxt.second_present = 1'b1;
            nxt.second_length  = state_i.arg_count;
            if (data_byte_i == clr_pkg::CH_CR) begin
              nxt.phase = clr_pkg::PH_LF;
            end else begin
              res = clr_pkg::RES_FAIL;
            end
          end
        end else if (!(data_byte_i inside {[clr_pkg::CH_BANG:clr_pkg::CH_TILDE]})) begin
          res = clr_pkg::RES_FAIL;
        end else begin
          argn          = 2'd2;
          nxt.arg_count = state_i.arg_count + 6'd1;
          res           = clr_pkg::RES_CHAR;
        end
      end
      clr_pkg::PH_CR: begin
        if (data_byte_i == clr_pkg::CH_CR) begin
          nxt.phase = clr_pkg::PH_LF;
        end else begin
          res = clr_pkg::RES_FAIL;
        end
      end
      clr_pkg::PH_LF: begin
        res = (data_byte_i == clr_pkg::CH_LF) ? clr_pkg::RES_OK : clr_pkg::RES_FAIL;
      end
      clr_pkg::PH_SKIP: begin
        res = clr_pkg::RES_NONE;
      end
      default: begin
        res = clr_pkg::RES_FAIL;
      end
    endcase

    // Chunk ran out before LF.
    if ((state_i.phase != clr_pkg::PH_SKIP) && chunk_end_i &&
        ((res == clr_pkg::RES_NONE) || (res == clr_pkg::RES_CHAR))) begin
      res = clr_pkg::RES_FAIL;
    end

    // After a verdict drop the rest of the chunk; a chunk end starts a new line.
    if ((state_i.phase == clr_pkg::PH_SKIP) ||
        (res == clr_pkg::RES_FAIL) || (res == clr_pkg::RES_OK)) begin
      if (chunk_end_i) begin
        nxt = clr_pkg::STATE_RESET;
      end else begin
        nxt.phase = clr_pkg::PH_SKIP;
      end
    end

    step_o.next_state = nxt;
    step_o.emit       = (res != clr_pkg::RES_NONE);

    step_o.result.kind       = (res != clr_pkg::RES_CHAR);
    step_o.result.arg_number = (res == clr_pkg::RES_CHAR) ? argn : 2'd0;
    step_o.result.arg_char   = (res == clr_pkg::RES_CHAR) ? data_byte_i : 8'd0;
    step_o.result.line_ok    = (res == clr_pkg::RES_OK);
    step_o.result.command_code =
      (res == clr_pkg::RES_OK) ? state_i.chosen_command : clr_pkg::CMD_NONE;
    step_o.result.first_arg_present =
      (res == clr_pkg::RES_OK) ? state_i.first_present : 1'b0;
    step_o.result.second_arg_present =
      (res == clr_pkg::RES_OK) ? state_i.second_present : 1'b0;
    step_o.result.first_arg_length =
      (res == clr_pkg::RES_OK) ? state_i.first_length : 6'd0;
    step_o.result.second_arg_length =
      (res == clr_pkg::RES_OK) ? state_i.second_length : 6'd0;
  end

endmodule

### rtl/clr_out_buf.sv
// Two-entry result buffer: output register plus skid register.
module clr_out_buf (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  clr_pkg::clr_result_t push_data_i,
  output logic                 space_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output clr_pkg::clr_result_t out_data_o
);

  logic                 out_valid_q, out_valid_d;
  logic                 skid_valid_q, skid_valid_d;
  clr_pkg::clr_result_t out_data_q, out_data_d;
  clr_pkg::clr_result_t skid_data_q, skid_data_d;
  logic                 pop;

  assign pop = out_valid_q && out_ready_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_data_d   = out_data_q;
    skid_data_d  = skid_data_q;
    if (skid_valid_q) begin
      // No push can arrive while the skid entry is full.
      if (pop) begin
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end
    end else if (push_i) begin
      if (!out_valid_q || pop) begin
        out_data_d  = push_data_i;
        out_valid_d = 1'b1;
      end else begin
        skid_data_d  = push_data_i;
        skid_valid_d = 1'b1;
      end
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign space_o     = !skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

### rtl/command_line_recognizer.sv
// Top level of the command line recognizer: line state, parser and result buffer.

// Takes one command byte per cycle and gives at most one result per byte: an
// argument character of LOGIN as it arrives, or the single verdict of the chunk
// (at LF, on the first error, or on the chunk's last byte). A byte is parsed in
// the cycle it is accepted, against the line state register, and its result is
// registered in the output buffer. Throughput is one byte per clock; the
// only thing that limits it is the consumer: results sit in a two-entry buffer
// (output register and skid register), so input ready drops only while both
// entries are full, i.e. after the consumer has held off for two results.
// Bytes after a verdict are swallowed until the chunk end flag, and the next
// chunk starts a fresh line. No configuration and no startup pass are needed.
module command_line_recognizer (
  input  logic      clk_i,
  input  logic      rst_ni,
  clr_in_if.sink    cmd_in_i,
  clr_out_if.source res_out_o
);

  clr_pkg::clr_state_t  state_q;
  clr_pkg::clr_state_t  state_d;
  clr_pkg::clr_step_t   step;
  clr_pkg::clr_result_t res_data;
  logic                 in_accept;
  logic                 buf_space;

  assign in_accept = cmd_in_i.valid && cmd_in_i.ready;

  // Parse the presented byte against the current line state.
  clr_parser u_parser (
    .state_i     (state_q),
    .data_byte_i (cmd_in_i.data_byte),
    .chunk_end_i (cmd_in_i.chunk_end),
    .step_o      (step)
  );

  // Advance the line state only on an accepted request; hold otherwise.
  assign state_d = in_accept ? step.next_state : state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= clr_pkg::STATE_RESET;
    end else begin
      state_q <= state_d;
    end
  end

  // Results go into the two-entry buffer; ready reflects a free skid entry.
  clr_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_accept && step.emit),
    .push_data_i (step.result),
    .space_o     (buf_space),
    .out_valid_o (res_out_o.valid),
    .out_ready_i (res_out_o.ready),
    .out_data_o  (res_data)
  );

  assign cmd_in_i.ready = buf_space;

  assign res_out_o.kind               = res_data.kind;
  assign res_out_o.arg_number         = res_data.arg_number;
  assign res_out_o.arg_char           = res_data.arg_char;
  assign res_out_o.line_ok            = res_data.line_ok;
  assign res_out_o.command_code       = res_data.command_code;
  assign res_out_o.first_arg_present  = res_data.first_arg_present;
  assign res_out_o.second_arg_present = res_data.second_arg_present;
  assign res_out_o.first_arg_length   = res_data.first_arg_length;
  assign res_out_o.second_arg_length  = res_data.second_arg_length;

  // Input stalls only when results are backed up on the output.
  a_stall_needs_backlog : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !cmd_in_i.ready |-> res_out_o.valid
  ) else $error("input stalled with no pending result");

  // A chunk end always leaves the parser waiting for a new command name.
  a_chunk_end_restarts : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    in_accept && cmd_in_i.chunk_end |=> (state_q.phase == clr_pkg::PH_NAME) &&
                                        (state_q.name_count == 5'd0)
  ) else $error("chunk end did not start a new line");

  // Passed characters always name argument one or two.
  a_char_has_arg : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    res_out_o.valid && !res_out_o.kind |-> (res_out_o.arg_number == 2'd1) ||
                                           (res_out_o.arg_number == 2'd2)
  ) else $error("argument character without argument number");

  // A failed verdict carries no command.
  a_fail_no_command : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    res_out_o.valid && res_out_o.kind && !res_out_o.line_ok |->
      (res_out_o.command_code == clr_pkg::CMD_NONE)
  ) else $error("failed verdict carries a command code");

endmodule
